@@ sv/rptb_pkg.sv @@
// ----------------------------------------------------------------------------
// rptb_pkg
// Types, constants and tables shared by the polygon transform block.
// ----------------------------------------------------------------------------
package rptb_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 32;
    localparam int NUM_VERTS      = 15;
    localparam int NUM_TRIS       = 13;
    localparam int NUM_RESULTS    = 29;
    localparam int CORDIC_STEPS   = 16;
    localparam int STEP_BITS      = 4;
    localparam int VIDX_BITS      = 4;
    localparam int RIDX_BITS      = 5;
    // Q2.30 working width for the rotator, with guard bits
    localparam int CW             = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_POLY   = 2'd1,
        KIND_TRI    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [15:0]        instance_req;
        logic [15:0]        angle;
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        tag;
        logic [1:0]         kind;
        logic [3:0]         part;
        logic signed [31:0] x_low;
        logic signed [31:0] x_high;
        logic signed [31:0] y_low;
        logic signed [31:0] y_high;
        logic               last;
    } out_item_t;

    // queue entry between front and back: tag, cos, sin, centre
    typedef struct packed {
        logic [15:0]            tag;
        logic signed [CW-1:0]   cos_v;
        logic signed [CW-1:0]   sin_v;
        logic signed [31:0]     cx;
        logic signed [31:0]     cy;
    } trig_t;

    function automatic logic [31:0] atan_turn(input logic [STEP_BITS-1:0] k);
        logic [31:0] r;
        case (k)
            4'd0:  r = 32'd536870912;
            4'd1:  r = 32'd316933406;
            4'd2:  r = 32'd167458907;
            4'd3:  r = 32'd85004756;
            4'd4:  r = 32'd42667331;
            4'd5:  r = 32'd21354465;
            4'd6:  r = 32'd10679838;
            4'd7:  r = 32'd5340245;
            4'd8:  r = 32'd2670163;
            4'd9:  r = 32'd1335087;
            4'd10: r = 32'd667544;
            4'd11: r = 32'd333772;
            4'd12: r = 32'd166886;
            4'd13: r = 32'd83443;
            4'd14: r = 32'd41722;
            default: r = 32'd20861;
        endcase
        return r;
    endfunction

    // base vertex coordinates, Q2.16 in 18 signed bits (Q16.16 scale)
    function automatic logic signed [17:0] vert_x(input logic [VIDX_BITS-1:0] v);
        logic signed [17:0] r;
        case (v)
            4'd0:  r = 18'sd0;
            4'd1:  r = 18'sd8192;
            4'd2:  r = 18'sd4096;
            4'd3:  r = 18'sd13107;
            4'd4:  r = 18'sd6554;
            4'd5:  r = 18'sd22938;
            4'd6:  r = 18'sd4915;
            4'd7:  r = 18'sd4915;
            4'd8:  r = -18'sd4915;
            4'd9:  r = -18'sd4915;
            4'd10: r = -18'sd22938;
            4'd11: r = -18'sd6554;
            4'd12: r = -18'sd13107;
            4'd13: r = -18'sd4096;
            4'd14: r = -18'sd8192;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [17:0] vert_y(input logic [VIDX_BITS-1:0] v);
        logic signed [17:0] r;
        case (v)
            4'd0:  r = 18'sd52429;
            4'd1, 4'd2, 4'd13, 4'd14: r = 18'sd32768;
            4'd3, 4'd4, 4'd11, 4'd12: r = 18'sd16384;
            4'd7, 4'd8: r = -18'sd13107;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    // triangle fan corners, packed {a,b,c}
    function automatic logic [11:0] tri_corners(input logic [VIDX_BITS-1:0] t);
        logic [11:0] r;
        case (t)
            4'd0:  r = {4'd0, 4'd1, 4'd2};
            4'd1:  r = {4'd2, 4'd3, 4'd4};
            4'd2:  r = {4'd0, 4'd2, 4'd4};
            4'd3:  r = {4'd4, 4'd5, 4'd6};
            4'd4:  r = {4'd0, 4'd4, 4'd6};
            4'd5:  r = {4'd0, 4'd6, 4'd7};
            4'd6:  r = {4'd0, 4'd7, 4'd8};
            4'd7:  r = {4'd0, 4'd8, 4'd9};
            4'd8:  r = {4'd9, 4'd10, 4'd11};
            4'd9:  r = {4'd0, 4'd9, 4'd11};
            4'd10: r = {4'd11, 4'd12, 4'd13};
            4'd11: r = {4'd0, 4'd11, 4'd13};
            default: r = {4'd0, 4'd13, 4'd14};
        endcase
        return r;
    endfunction

endpackage

@@ sv/rptb_front.sv @@
// ----------------------------------------------------------------------------
// rptb_front
// Accepts instance items and runs a 16-step iterative CORDIC for sin/cos.
// ----------------------------------------------------------------------------
module rptb_front
    import rptb_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     q_valid,
    input  logic     q_ready,
    output trig_t    q_item
);

    // only the low ANGLE_BITS of the angle count, scaled to a 32-bit turn
    localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;
    logic signed [CW-1:0]    x_reg, x_next, y_reg, y_next;
    logic signed [32:0]      z_reg, z_next;
    logic                    flip_reg, flip_next;
    logic [15:0]             tag_reg, tag_next;
    logic signed [31:0]      cx_reg, cx_next, cy_reg, cy_next;

    logic [31:0]             a_turn;
    logic                    flip_in;
    logic [31:0]             a_fold;
    logic signed [CW-1:0]    dx, dy;
    logic signed [32:0]      at;

    always_comb
    begin
        a_turn  = ({16'h0000, in_item.angle} & ANG_MASK) << (32 - ANGLE_BITS);
        flip_in = a_turn[31] ^ a_turn[30];
        a_fold  = flip_in ? (a_turn - 32'h8000_0000) : a_turn;
        dx      = y_reg >>> step_reg;
        dy      = x_reg >>> step_reg;
        at      = {1'b0, atan_turn(step_reg)};
    end

    assign in_ready = !busy_reg && !done_reg;
    assign q_valid  = done_reg;
    assign q_item.tag   = tag_reg;
    assign q_item.cos_v = flip_reg ? -x_reg : x_reg;
    assign q_item.sin_v = flip_reg ? -y_reg : y_reg;
    assign q_item.cx    = cx_reg;
    assign q_item.cy    = cy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        tag_next  = tag_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        if (in_valid && in_ready)
        begin
            busy_next = 1'b1;
            step_next = '0;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = {a_fold[31], a_fold};
            flip_next = flip_in;
            tag_next  = in_item.instance_req;
            cx_next   = in_item.centre_x;
            cy_next   = in_item.centre_y;
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_BITS'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg && q_ready)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        tag_reg  <= tag_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
    end

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg)) else $error("front busy and done together");
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg == STEP_BITS'(CORDIC_STEPS - 1) |=> done_reg)
        else $error("cordic did not finish");

endmodule

@@ sv/rptb_queue.sv @@
// ----------------------------------------------------------------------------
// rptb_queue
// Two-entry queue of trig items between front and back.
// ----------------------------------------------------------------------------
module rptb_queue
    import rptb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  trig_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output trig_t rd_item
);

    trig_t       mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        wr_en, rd_en;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_item  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= !wp_reg;
            if (rd_en) rp_reg <= !rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_item;
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");

endmodule

@@ sv/rptb_back.sv @@
// ----------------------------------------------------------------------------
// rptb_back
// Transforms vertices one per cycle unless the output stalls, then emits polygon and triangle boxes.
// ----------------------------------------------------------------------------
module rptb_back
    import rptb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  trig_t     q_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int PW = 54;
    // stored coordinate width: full saturated value, at least the field width
    localparam int SW = (COORD_BITS > 32) ? COORD_BITS : 32;
    localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - 1;

    // stage 0: sequencer
    logic                 act_reg;
    logic [RIDX_BITS-1:0] idx_reg;
    trig_t                cur_reg;
    // stage 1: products registered
    logic                 s1_v_reg;
    logic [RIDX_BITS-1:0] s1_idx_reg;
    logic signed [PW-1:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    trig_t                s1_t_reg;
    // vertex store and running box
    logic signed [SW-1:0] vx_reg [NUM_VERTS];
    logic signed [SW-1:0] vy_reg [NUM_VERTS];
    logic signed [SW-1:0] mnx_reg, mxx_reg, mny_reg, mxy_reg;
    // output register
    logic                 ov_reg;
    out_item_t            o_reg;

    logic                 stall;
    logic                 adv;
    logic                 load;
    logic [VIDX_BITS-1:0] vi;
    logic signed [17:0]   bx, by;
    logic signed [PW-1:0] rx, ry, sx, sy;
    logic signed [SW-1:0] wx, wy;
    logic [VIDX_BITS-1:0] ti;
    logic [11:0]          tc;
    logic signed [SW-1:0] ax, bx2, cx2, ay, by2, cy2;
    logic signed [SW-1:0] tlx, thx, tly, thy;
    out_item_t            o_next;

    assign stall = ov_reg && !out_ready;
    assign adv   = !stall;
    assign load  = adv && (!act_reg || idx_reg == RIDX_BITS'(NUM_RESULTS - 1)) && q_valid;
    assign q_ready = adv && (!act_reg || idx_reg == RIDX_BITS'(NUM_RESULTS - 1));
    assign vi    = idx_reg[VIDX_BITS-1:0];
    assign bx    = vert_x(vi);
    assign by    = vert_y(vi);

    function automatic logic signed [PW-1:0] sat(input logic signed [PW-1:0] v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    always_comb
    begin
        rx = (pxc_reg - pys_reg + (PW'(1) <<< 29)) >>> 30;
        ry = (pxs_reg + pyc_reg + (PW'(1) <<< 29)) >>> 30;
        sx = sat(rx + PW'(s1_t_reg.cx));
        sy = sat(ry + PW'(s1_t_reg.cy));
        wx = sx[SW-1:0];
        wy = sy[SW-1:0];
    end

    // box pass reads the vertex store once the vertex stage has drained
    always_comb
    begin
        ti  = VIDX_BITS'(idx_reg - RIDX_BITS'(NUM_VERTS + 1));
        tc  = tri_corners(ti);
        ax  = vx_reg[tc[11:8]]; bx2 = vx_reg[tc[7:4]]; cx2 = vx_reg[tc[3:0]];
        ay  = vy_reg[tc[11:8]]; by2 = vy_reg[tc[7:4]]; cy2 = vy_reg[tc[3:0]];
        tlx = (ax < bx2) ? ((ax < cx2) ? ax : cx2) : ((bx2 < cx2) ? bx2 : cx2);
        thx = (ax > bx2) ? ((ax > cx2) ? ax : cx2) : ((bx2 > cx2) ? bx2 : cx2);
        tly = (ay < by2) ? ((ay < cy2) ? ay : cy2) : ((by2 < cy2) ? by2 : cy2);
        thy = (ay > by2) ? ((ay > cy2) ? ay : cy2) : ((by2 > cy2) ? by2 : cy2);
        o_next = o_reg;
        o_next.tag  = cur_reg.tag;
        o_next.last = 1'b0;
        if (s1_v_reg)
        begin
            o_next.tag    = s1_t_reg.tag;
            o_next.kind   = KIND_VERTEX;
            o_next.part   = s1_idx_reg[3:0];
            o_next.x_low  = wx[31:0]; o_next.x_high = wx[31:0];
            o_next.y_low  = wy[31:0]; o_next.y_high = wy[31:0];
        end
        else if (idx_reg == RIDX_BITS'(NUM_VERTS))
        begin
            o_next.kind   = KIND_POLY;
            o_next.part   = '0;
            o_next.x_low  = mnx_reg[31:0]; o_next.x_high = mxx_reg[31:0];
            o_next.y_low  = mny_reg[31:0]; o_next.y_high = mxy_reg[31:0];
        end
        else
        begin
            o_next.kind   = KIND_TRI;
            o_next.part   = ti;
            o_next.x_low  = tlx[31:0];
            o_next.x_high = thx[31:0];
            o_next.y_low  = tly[31:0];
            o_next.y_high = thy[31:0];
            o_next.last   = idx_reg == RIDX_BITS'(NUM_RESULTS - 1);
        end
    end

    // box results are emitted from stage 0 once the last vertex left stage 1
    logic emit_box;
    assign emit_box = act_reg && !s1_v_reg && idx_reg > RIDX_BITS'(NUM_VERTS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            idx_reg  <= '0;
            s1_v_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= act_reg && idx_reg < RIDX_BITS'(NUM_VERTS) && !load;
            ov_reg   <= s1_v_reg || emit_box;
            if (load)
            begin
                act_reg <= 1'b1;
                idx_reg <= '0;
                s1_v_reg <= 1'b0;
            end
            else if (act_reg)
            begin
                // hold at vertex count while the last vertex drains
                if (idx_reg < RIDX_BITS'(NUM_VERTS) || emit_box)
                    idx_reg <= idx_reg + 1'b1;
                if (idx_reg == RIDX_BITS'(NUM_RESULTS - 1) && emit_box)
                    act_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_item;
        if (adv)
        begin
            pxc_reg    <= PW'(bx * cur_reg.cos_v);
            pys_reg    <= PW'(by * cur_reg.sin_v);
            pxs_reg    <= PW'(bx * cur_reg.sin_v);
            pyc_reg    <= PW'(by * cur_reg.cos_v);
            s1_idx_reg <= idx_reg;
            s1_t_reg   <= cur_reg;
            if (s1_v_reg || emit_box)
                o_reg <= o_next;
            if (s1_v_reg)
            begin
                vx_reg[s1_idx_reg[3:0]] <= wx;
                vy_reg[s1_idx_reg[3:0]] <= wy;
                if (s1_idx_reg == '0)
                begin
                    mnx_reg <= wx; mxx_reg <= wx; mny_reg <= wy; mxy_reg <= wy;
                end
                else
                begin
                    if (wx < mnx_reg) mnx_reg <= wx;
                    if (wx > mxx_reg) mxx_reg <= wx;
                    if (wy < mny_reg) mny_reg <= wy;
                    if (wy > mxy_reg) mxy_reg <= wy;
                end
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_item  = o_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> ov_reg && $stable(o_reg)) else $error("result changed under stall");
    a_noboth: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_v_reg && emit_box)) else $error("vertex and box collide");

endmodule

@@ sv/rigid_polygon_transform_bounds.sv @@
// ----------------------------------------------------------------------------
// rigid_polygon_transform_bounds
// Rotates and translates a fixed 15-vertex polygon, emits vertices and boxes.
// ----------------------------------------------------------------------------
// Path to the first result: 16 CORDIC steps, queue, product and sum stages.
// Items are paced by the back part's result sequencer, which takes the next
// item as it emits the current one's last box; the CORDIC of the next item
// overlaps the current item's results.
// Reset: asynchronous, active low; clears control only, no clearing pass.
module rigid_polygon_transform_bounds
    import rptb_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    // front: CORDIC sin/cos per item
    logic  f_valid, f_ready;
    trig_t f_item;
    // queue to back
    logic  b_valid, b_ready;
    trig_t b_item;

    rptb_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
    );

    rptb_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
    );

    // back: vertex transform and box sequencer
    rptb_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rigid_polygon_transform_bounds: directed table,
// then random instances, each checked result by result against a CORDIC model.
// ----------------------------------------------------------------------------
module tb_top
    import rptb_pkg::*;
();

    // Q16.16 base polygon and triangle fan, held locally for the model
    localparam longint BASE_X [15] = '{0, 8192, 4096, 13107, 6554, 22938, 4915, 4915,
        -4915, -4915, -22938, -6554, -13107, -4096, -8192};
    localparam longint BASE_Y [15] = '{52429, 32768, 32768, 16384, 16384, 0, 0, -13107,
        -13107, 0, 0, 16384, 16384, 32768, 32768};
    localparam int FAN [13][3] = '{'{0, 1, 2}, '{2, 3, 4}, '{0, 2, 4}, '{4, 5, 6},
        '{0, 4, 6}, '{0, 6, 7}, '{0, 7, 8}, '{0, 8, 9}, '{9, 10, 11}, '{0, 9, 11},
        '{11, 12, 13}, '{0, 11, 13}, '{0, 13, 14}};
    localparam longint ROT_ATAN [16] = '{536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861};
    localparam int N_RANDOM = 350;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    out_item_t pending_results[$];
    int        errors = 0;
    int        n_items = 0;
    int        n_results = 0;
    int        n_saturated = 0;
    // idling percentages, changed per phase
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    always #1 clk = ~clk;

    rigid_polygon_transform_bounds uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    // Directed table: a typed value, where given, replaces the predicted
    // coordinate of one vertex, also in its boxes (saturation cases are obvious by eye).
    typedef struct {
        in_item_t    it;
        bit          typed;
        int          vtx;
        bit          on_y;
        logic [31:0] val;
    } dir_row_t;

    localparam int N_DIR = 14;
    dir_row_t dir_rows [N_DIR] = '{
        '{'{16'h0000, 16'h0000, 32'sh0, 32'sh0}, 0, 0, 0, 0},
        '{'{16'hFFFF, 16'hFFFF, 32'sh0, 32'sh0}, 0, 0, 0, 0},
        '{'{16'h1234, 16'h4000, 32'sh0001_0000, -32'sh0001_0000}, 0, 0, 0, 0},
        '{'{16'h5555, 16'h8000, 32'sh0, 32'sh0}, 0, 0, 0, 0},
        '{'{16'hAAAA, 16'hC000, 32'sh0, 32'sh0}, 0, 0, 0, 0},
        '{'{16'h0001, 16'h2000, 32'sh0, 32'sh0}, 0, 0, 0, 0},
        // either side of the half-turn fold
        '{'{16'h0002, 16'h3FFF, 32'sh0, 32'sh0}, 0, 0, 0, 0},
        '{'{16'h0003, 16'hBFFF, 32'sh0, 32'sh0}, 0, 0, 0, 0},
        '{'{16'h0004, 16'hC001, 32'sh0, 32'sh0}, 0, 0, 0, 0},
        // saturation at the coordinate limits
        '{'{16'h00F0, 16'h0000, 32'sh7FFF_FFFF, 32'sh0}, 1, 5, 0, S_MAX},
        '{'{16'h00F1, 16'h8000, -32'sh8000_0000, 32'sh0}, 1, 5, 0, S_MIN},
        '{'{16'h00F2, 16'h0000, 32'sh0, 32'sh7FFF_FFFF}, 1, 0, 1, S_MAX},
        '{'{16'h00F3, 16'h8000, 32'sh0, -32'sh8000_0000}, 1, 0, 1, S_MIN},
        '{'{16'h0F0F, 16'h7777, -32'sh8000_0000, 32'sh7FFF_FFFF}, 0, 0, 0, 0}
    };

    function automatic logic [31:0] clamp_coord(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return S_MAX;
        if (v < -longint'(64'sh8000_0000))
            return S_MIN;
        return v[31:0];
    endfunction

    // CORDIC cos/sin in Q2.30 for a 16-bit turn angle
    task automatic rotor(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] a;
        bit          fold;
        longint      x, y, z, dx, dy;
        a = {ang, 16'h0000};
        fold = a[31] ^ a[30];
        if (fold)
            a = a - 32'h8000_0000;
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int k = 0; k < 16; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ROT_ATAN[k];
            end
            else
            begin
                x += dx; y -= dy; z += ROT_ATAN[k];
            end
        end
        c = fold ? -x : x;
        s = fold ? -y : y;
    endtask

    // Push the 29 results one instance should produce
    task automatic predict_instance(input in_item_t it, input dir_row_t row,
                                    input bit use_row);
        longint      c, s, rx, ry;
        logic [31:0] wx [15];
        logic [31:0] wy [15];
        out_item_t   r;
        int          a;
        rotor(it.angle, c, s);
        for (int v = 0; v < 15; v++)
        begin
            rx = (BASE_X[v] * c - BASE_Y[v] * s + (64'sd1 <<< 29)) >>> 30;
            ry = (BASE_X[v] * s + BASE_Y[v] * c + (64'sd1 <<< 29)) >>> 30;
            wx[v] = clamp_coord(rx + longint'(it.centre_x));
            wy[v] = clamp_coord(ry + longint'(it.centre_y));
            if (wx[v] == S_MAX || wx[v] == S_MIN || wy[v] == S_MAX || wy[v] == S_MIN)
                n_saturated++;
        end
        if (use_row && row.typed)
        begin
            if (row.on_y)
                wy[row.vtx] = row.val;
            else
                wx[row.vtx] = row.val;
        end
        for (int v = 0; v < 15; v++)
        begin
            r = '{it.instance_req, KIND_VERTEX, 4'(v), wx[v], wx[v], wy[v], wy[v], 1'b0};
            pending_results.push_back(r);
        end
        r = '{it.instance_req, KIND_POLY, 4'd0, wx[0], wx[0], wy[0], wy[0], 1'b0};
        for (int v = 1; v < 15; v++)
        begin
            if ($signed(wx[v]) < $signed(r.x_low))  r.x_low  = wx[v];
            if ($signed(wx[v]) > $signed(r.x_high)) r.x_high = wx[v];
            if ($signed(wy[v]) < $signed(r.y_low))  r.y_low  = wy[v];
            if ($signed(wy[v]) > $signed(r.y_high)) r.y_high = wy[v];
        end
        pending_results.push_back(r);
        for (int t = 0; t < 13; t++)
        begin
            a = FAN[t][0];
            r = '{it.instance_req, KIND_TRI, 4'(t), wx[a], wx[a], wy[a], wy[a], t == 12};
            for (int j = 1; j < 3; j++)
            begin
                a = FAN[t][j];
                if ($signed(wx[a]) < $signed(r.x_low))  r.x_low  = wx[a];
                if ($signed(wx[a]) > $signed(r.x_high)) r.x_high = wx[a];
                if ($signed(wy[a]) < $signed(r.y_low))  r.y_low  = wy[a];
                if ($signed(wy[a]) > $signed(r.y_high)) r.y_high = wy[a];
            end
            pending_results.push_back(r);
        end
    endtask

    // Present one item, hold it until taken, then maybe go idle
    task automatic offer(input in_item_t it, input dir_row_t row, input bit use_row);
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_instance(it, row, use_row);
        n_items++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    function automatic logic [31:0] rand_centre();
        case ($urandom_range(9))
            0: return S_MAX - $urandom_range(40000);
            1: return S_MIN + $urandom_range(40000);
            2: return $urandom();
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    // receiver stall pattern
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, out_item);
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("tag", 32'(e.tag), 32'(out_item.tag));
                check_field("kind", 32'(e.kind), 32'(out_item.kind));
                check_field("part", 32'(e.part), 32'(out_item.part));
                check_field("x_low", e.x_low, out_item.x_low);
                check_field("x_high", e.x_high, out_item.x_high);
                check_field("y_low", e.y_low, out_item.y_low);
                check_field("y_high", e.y_high, out_item.y_high);
                check_field("last", 32'(e.last), 32'(out_item.last));
            end
        end
    end

    initial
    begin
        in_item_t it;
        dir_row_t none;
        none = '{'0, 0, 0, 0, 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (int i = 0; i < N_DIR; i++)
            offer(dir_rows[i].it, dir_rows[i], 1'b1);

        // random instances over four idling phases
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case (i)
                0:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                90:  begin send_idle_pct = 70; recv_stall_pct = 0;  end
                180: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                270: begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: ;
            endcase
            if (i == 200)
            begin
                // drain completely before carrying on
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            it.instance_req = 16'($urandom());
            it.angle        = 16'($urandom());
            it.centre_x     = rand_centre();
            it.centre_y     = rand_centre();
            offer(it, none, 1'b0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d instances, %0d results checked, %0d saturated vertices,",
                 n_items, n_results, n_saturated);
        $display("four idling phases and one full drain mid-run; %0d errors.", errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
